FILE: rtl/lcmb_pkg.sv
// shared constants, types and codes for the led channel mode and blink controller
`default_nettype none
package lcmb_pkg;

  localparam int CHANNELS       = 8;
  localparam int PWM_FULL_SCALE = 255;
  localparam int TICKS_PER_UNIT = 50;

  localparam int LEVEL_W = 8;
  localparam int CNT_W   = 14;
  localparam int N_W     = 4;
  localparam int SEL_W   = 3;
  localparam int TICK_W  = $clog2(TICKS_PER_UNIT + 1);
  localparam int PROD_W  = 2 * LEVEL_W;
  localparam int HI_W    = PROD_W + TICK_W;
  localparam int LHS_W   = CNT_W + 1 + LEVEL_W;
  localparam int CMP_W   = (HI_W > LHS_W) ? HI_W : LHS_W;
  localparam int PT_W    = LEVEL_W + TICK_W;
  localparam int WRAP_W  = (PT_W > CNT_W + 1) ? PT_W : CNT_W + 1;
  localparam int OUT_W   = 64;

  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] CFG_GROUP_PERIOD  = 2'd1;
  localparam logic [1:0] CFG_GROUP_DUTY    = 2'd2;

  typedef enum logic [1:0] {
    CMD_SET_MODES = 2'd0,
    CMD_DIM       = 2'd1,
    CMD_TICK      = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_FULL  = 2'd1,
    MODE_LEVEL = 2'd2,
    MODE_BLINK = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_MUL  = 2'd1,
    S_HIGH = 2'd2,
    S_DONE = 2'd3
  } state_t;

  typedef struct packed {
    logic stage1;
    logic stage2;
    logic apply;
    logic tick_en;
    cmd_t cmd;
  } lane_ctrl_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] shown;
    logic               blink;
  } lane_stat_t;

endpackage
`default_nettype wire

FILE: rtl/led_channel_mode_blink_ctrl_core.sv
// top level: request sequencer, config registers, channel lanes and merging stage
//
//   channel  signals                                   direction
//   input    in_valid in_ready cmd led_mode_word       request in
//            pwm_values
//   output   out_valid out_ready pwm_out               result out
//   config   cfg_valid cfg_ready cfg_index cfg_data    register write in
//
// every request passes through accept, the per*duty, count*scale and period*ticks
// multiplies, the times-ticks multiply, then the lane update.
// the unused command is taken and dropped in its accept cycle.
// the per*duty product feeds the times-ticks multiply; all lanes run at once.
// reset clears the lane levels, blink settings and counters; config registers return to their defaults.
// a finished result waits in the output register while the next request is taken;
// only a new result stalls behind an unaccepted one.
`default_nettype none
module led_channel_mode_blink_ctrl_core (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [1:0]                         cmd,
  input  wire  [15:0]                        led_mode_word,
  input  wire  [lcmb_pkg::OUT_W-1:0]         pwm_values,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [lcmb_pkg::OUT_W-1:0]         pwm_out,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [1:0]                         cfg_index,
  input  wire  [7:0]                         cfg_data
);

  lcmb_pkg::state_t state, state_next;

  logic [lcmb_pkg::N_W-1:0]     channel_count;
  logic [lcmb_pkg::LEVEL_W-1:0] group_period;
  logic [lcmb_pkg::LEVEL_W-1:0] group_duty;
  logic                         blink_active;

  lcmb_pkg::cmd_t               cmd_r;
  logic [15:0]                  mode_r;
  logic [lcmb_pkg::OUT_W-1:0]   bytes_r;
  logic [lcmb_pkg::N_W-1:0]     n_r;

  lcmb_pkg::lane_ctrl_t         ctrl;
  lcmb_pkg::lane_stat_t         stat [lcmb_pkg::CHANNELS];
  logic [lcmb_pkg::CHANNELS-1:0] used;
  logic [lcmb_pkg::CHANNELS-1:0] blink_vec;
  logic [lcmb_pkg::SEL_W-1:0]   sel [lcmb_pkg::CHANNELS];

  logic accept, emit, go, any_blink;

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= lcmb_pkg::N_W'(lcmb_pkg::CHANNELS);
      group_period  <= '0;
      group_duty    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lcmb_pkg::CFG_CHANNEL_COUNT: channel_count <= cfg_data[lcmb_pkg::N_W-1:0];
        lcmb_pkg::CFG_GROUP_PERIOD:  group_period  <= cfg_data;
        lcmb_pkg::CFG_GROUP_DUTY:    group_duty    <= cfg_data;
        default:                     group_duty    <= group_duty;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= lcmb_pkg::cmd_t'(cmd);
      mode_r  <= led_mode_word;
      bytes_r <= pwm_values;
      n_r     <= (channel_count > lcmb_pkg::N_W'(lcmb_pkg::CHANNELS))
                 ? lcmb_pkg::N_W'(lcmb_pkg::CHANNELS) : channel_count;
    end
  end

  // byte selection: running count of lanes that take a packed byte
  always_comb begin
    logic [lcmb_pkg::SEL_W-1:0] next_idx;
    next_idx = '0;
    for (int i = 0; i < lcmb_pkg::CHANNELS; i++) begin
      used[i] = lcmb_pkg::N_W'(i) < n_r;
      sel[i]  = next_idx;
      if (used[i] && mode_r[2*i+1]) begin
        next_idx = next_idx + lcmb_pkg::SEL_W'(1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < lcmb_pkg::CHANNELS; i++) begin
      blink_vec[i] = stat[i].blink;
    end
  end

  assign any_blink = |blink_vec;

  always_comb begin
    case (cmd_r)
      lcmb_pkg::CMD_SET_MODES: emit = !any_blink;
      lcmb_pkg::CMD_DIM:       emit = 1'b1;
      lcmb_pkg::CMD_TICK:      emit = blink_active;
      default:                 emit = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    case (state)
      lcmb_pkg::S_IDLE: begin
        state_next = (accept && (lcmb_pkg::cmd_t'(cmd) != lcmb_pkg::CMD_NONE))
                     ? lcmb_pkg::S_MUL : lcmb_pkg::S_IDLE;
      end
      lcmb_pkg::S_MUL:  state_next = lcmb_pkg::S_HIGH;
      lcmb_pkg::S_HIGH: state_next = lcmb_pkg::S_DONE;
      lcmb_pkg::S_DONE: state_next = go ? lcmb_pkg::S_IDLE : lcmb_pkg::S_DONE;
      default:          state_next = lcmb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcmb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // outputs of the sequencer
  always_comb begin
    in_ready     = 1'b0;
    ctrl.stage1  = 1'b0;
    ctrl.stage2  = 1'b0;
    go           = 1'b0;
    case (state)
      lcmb_pkg::S_IDLE: in_ready    = 1'b1;
      lcmb_pkg::S_MUL:  ctrl.stage1 = 1'b1;
      lcmb_pkg::S_HIGH: ctrl.stage2 = 1'b1;
      lcmb_pkg::S_DONE: go          = !emit || !out_valid || out_ready;
      default:          go          = 1'b0;
    endcase
    ctrl.apply   = go;
    ctrl.tick_en = blink_active;
    ctrl.cmd     = cmd_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_active <= 1'b0;
    end else if (go) begin
      case (cmd_r)
        lcmb_pkg::CMD_SET_MODES: blink_active <= any_blink;
        lcmb_pkg::CMD_DIM:       blink_active <= 1'b0;
        default:                 blink_active <= blink_active;
      endcase
    end
  end

  for (genvar g = 0; g < lcmb_pkg::CHANNELS; g++) begin : g_lane
    lcmb_lane u_lane (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .used         (used[g]),
      .mode         (lcmb_pkg::mode_t'(mode_r[2*g +: 2])),
      .byte_set     (bytes_r[lcmb_pkg::LEVEL_W*sel[g] +: lcmb_pkg::LEVEL_W]),
      .byte_dim     (bytes_r[lcmb_pkg::LEVEL_W*g +: lcmb_pkg::LEVEL_W]),
      .group_period (group_period),
      .group_duty   (group_duty),
      .stat         (stat[g])
    );
  end

  lcmb_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (go && emit),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pwm_out   (pwm_out)
  );

endmodule
`default_nettype wire

FILE: rtl/lcmb_lane.sv
// one channel lane: level, blink settings, blink counter and gating
`default_nettype none
module lcmb_lane (
  input  wire                                clk,
  input  wire                                rst,
  input  lcmb_pkg::lane_ctrl_t               ctrl,
  input  wire                                used,
  input  lcmb_pkg::mode_t                    mode,
  input  wire  [lcmb_pkg::LEVEL_W-1:0]       byte_set,
  input  wire  [lcmb_pkg::LEVEL_W-1:0]       byte_dim,
  input  wire  [lcmb_pkg::LEVEL_W-1:0]       group_period,
  input  wire  [lcmb_pkg::LEVEL_W-1:0]       group_duty,
  output lcmb_pkg::lane_stat_t               stat
);

  logic [lcmb_pkg::LEVEL_W-1:0] level, level_next;
  logic [lcmb_pkg::LEVEL_W-1:0] period, period_next;
  logic [lcmb_pkg::LEVEL_W-1:0] duty, duty_next;
  logic [lcmb_pkg::CNT_W-1:0]   count, count_next;

  logic [lcmb_pkg::PROD_W-1:0]  prod;
  logic [lcmb_pkg::HI_W-1:0]    high;
  logic [lcmb_pkg::LHS_W-1:0]   lhs;
  logic [lcmb_pkg::PT_W-1:0]    per_ticks;

  logic [lcmb_pkg::CNT_W:0]     cnt_inc;
  logic                         gate;
  logic                         tick_live;

  assign cnt_inc   = {1'b0, count} + (lcmb_pkg::CNT_W + 1)'(1);
  assign tick_live = used && ctrl.tick_en && (ctrl.cmd == lcmb_pkg::CMD_TICK)
                     && (period != '0);

  // multiplier stages, read back when the request finishes
  always_ff @(posedge clk) begin
    if (ctrl.stage1) begin
      prod      <= lcmb_pkg::PROD_W'(period) * lcmb_pkg::PROD_W'(duty);
      lhs       <= lcmb_pkg::LHS_W'(count) * lcmb_pkg::LHS_W'(lcmb_pkg::PWM_FULL_SCALE);
      per_ticks <= lcmb_pkg::PT_W'(period) * lcmb_pkg::PT_W'(lcmb_pkg::TICKS_PER_UNIT);
    end
    if (ctrl.stage2) begin
      high <= lcmb_pkg::HI_W'(prod) * lcmb_pkg::HI_W'(lcmb_pkg::TICKS_PER_UNIT);
    end
  end

  // count > period*duty*ticks/scale is the same as count*scale > period*duty*ticks
  always_comb begin
    level_next  = level;
    period_next = period;
    duty_next   = duty;
    count_next  = count;
    gate        = 1'b0;
    case (ctrl.cmd)
      lcmb_pkg::CMD_SET_MODES: begin
        if (used) begin
          case (mode)
            lcmb_pkg::MODE_OFF:  level_next = '0;
            lcmb_pkg::MODE_FULL: level_next = lcmb_pkg::LEVEL_W'(lcmb_pkg::PWM_FULL_SCALE);
            lcmb_pkg::MODE_LEVEL: begin
              level_next  = byte_set;
              period_next = '0;
              duty_next   = '0;
            end
            lcmb_pkg::MODE_BLINK: begin
              level_next  = byte_set;
              period_next = group_period;
              duty_next   = group_duty;
            end
            default: level_next = level;
          endcase
        end
      end
      lcmb_pkg::CMD_DIM: begin
        if (used) begin
          level_next = byte_dim;
        end
      end
      lcmb_pkg::CMD_TICK: begin
        if (tick_live) begin
          gate = lcmb_pkg::CMP_W'(lhs) > lcmb_pkg::CMP_W'(high);
          if (lcmb_pkg::WRAP_W'(cnt_inc) >= lcmb_pkg::WRAP_W'(per_ticks)) begin
            count_next = '0;
          end else begin
            count_next = cnt_inc[lcmb_pkg::CNT_W-1:0];
          end
        end
      end
      default: gate = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level  <= '0;
      period <= '0;
      duty   <= '0;
      count  <= '0;
    end else if (ctrl.apply) begin
      level  <= level_next;
      period <= period_next;
      duty   <= duty_next;
      count  <= count_next;
    end
  end

  assign stat.shown = gate ? '0 : level_next;
  assign stat.blink = used && (ctrl.cmd == lcmb_pkg::CMD_SET_MODES)
                      && (mode == lcmb_pkg::MODE_BLINK);

endmodule
`default_nettype wire

FILE: rtl/lcmb_merge.sv
// merging stage: packs lane levels into the result word and holds it for the output channel
`default_nettype none
module lcmb_merge (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              load,
  input  lcmb_pkg::lane_stat_t             stat [lcmb_pkg::CHANNELS],
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [lcmb_pkg::OUT_W-1:0]       pwm_out
);

  logic [lcmb_pkg::OUT_W-1:0] packed_word;

  always_comb begin
    packed_word = '0;
    for (int i = 0; i < lcmb_pkg::CHANNELS; i++) begin
      packed_word[lcmb_pkg::LEVEL_W*i +: lcmb_pkg::LEVEL_W] = stat[i].shown;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pwm_out <= packed_word;
    end
  end

endmodule
`default_nettype wire
